### design/jsu_pkg.sv
// shared types and codes for the json string unescaper
package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       run_last;
    } t_out_item;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_DONE = 2'd1,
        TERM_ERR  = 2'd2
    } t_term;

    // all results caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      byte_count;
        t_term           term;
    } t_group;

    typedef struct packed {
        logic push;
        logic full;
    } t_wr_ctl;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_rd_ctl;

endpackage

### design/json_string_unescape_utf8_core.sv
// top level of the json string unescaper
// Input channel: one raw text beat per accepted item (text_byte, end_of_text),
// starting at the opening quote of a string literal.
// Output channel: one result per beat: a decoded UTF-8 byte (status 0), a done
// marker (status 1) or an error marker (status 2); run_last flags the final
// result made by an input beat. On an error the consumer drops the bytes
// already received for that string; the block then waits for a new quote.
// Throughput: one input beat per cycle while the group queue has room. Each
// input beat gives zero to five results and the output side sends one result
// a cycle while the receiver is ready, so while the four bytes of a surrogate
// pair go out, the front keeps taking input until the four-deep queue fills.
// A beat's group is queued as the beat is accepted and offered after older groups.
// Reset: synchronous active low; clears scanner state and empties the queue.
// Output stall: results wait in the queue, the front stops taking beats
// only when the queue is full.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_group  grp_in, grp_head;
    t_wr_ctl wr;
    t_rd_ctl rd;
    logic    push;
    logic    full;
    logic    empty;
    logic    pop;

    assign wr.push  = push;
    assign wr.full  = full;
    assign rd.pop   = pop;
    assign rd.empty = empty;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (wr.full),
        .o_push     (push),
        .o_group    (grp_in)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_full  (full),
        .i_group (grp_in),
        .i_pop   (rd.pop),
        .o_empty (empty),
        .o_head  (grp_head)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (rd),
        .i_head      (grp_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/jsu_front.sv
// front part: scanner state machine that turns each text byte into a result group
module jsu_front
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_full,
    output logic     o_push,
    output t_group   o_group
);

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_BODY   = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_HEX1   = 7'b0001000,
        PH_PAIRBS = 7'b0010000,
        PH_PAIRU  = 7'b0100000,
        PH_HEX2   = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    t_group      grp;
    logic [7:0]  ch;
    logic [4:0]  hexd;
    logic [15:0] code;
    logic [20:0] pair_cp;
    logic        accept;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic t_group utf8_encode(input logic [20:0] v);
        t_group g;
        g = '0;
        g.term = TERM_NONE;
        if (v <= 21'h7f) begin
            g.bytes[0]   = v[7:0];
            g.byte_count = 3'd1;
        end else if (v <= 21'h7ff) begin
            g.bytes[0]   = 8'hc0 | {3'b000, v[10:6]};
            g.bytes[1]   = 8'h80 | {2'b00, v[5:0]};
            g.byte_count = 3'd2;
        end else if (v <= 21'hffff) begin
            g.bytes[0]   = 8'he0 | {4'h0, v[15:12]};
            g.bytes[1]   = 8'h80 | {2'b00, v[11:6]};
            g.bytes[2]   = 8'h80 | {2'b00, v[5:0]};
            g.byte_count = 3'd3;
        end else begin
            g.bytes[0]   = 8'hf0 | {5'h00, v[20:18]};
            g.bytes[1]   = 8'h80 | {2'b00, v[17:12]};
            g.bytes[2]   = 8'h80 | {2'b00, v[11:6]};
            g.bytes[3]   = 8'h80 | {2'b00, v[5:0]};
            g.byte_count = 3'd4;
        end
        return g;
    endfunction

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign ch         = i_in_data.text_byte;
    assign hexd       = hex_value(ch);
    assign code       = {r_acc, hexd[3:0]};
    // 0x10000 plus the pair bits: the offset lands above bit ten
    assign pair_cp    = {11'({1'b0, r_hs} + 11'd64), code[9:0]};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        grp     = '0;
        grp.term = TERM_NONE;
        unique case (r_phase) inside
            PH_IDLE: begin
                if (ch == 8'h22) n_phase = PH_BODY;
                else grp.term = TERM_ERR;
            end
            PH_BODY: begin
                if (ch == 8'h22) begin
                    grp.term = TERM_DONE;
                    n_phase  = PH_IDLE;
                end else if (ch < 8'h20) begin
                    grp.term = TERM_ERR;
                end else if (ch == 8'h5c) begin
                    n_phase = PH_ESC;
                end else begin
                    grp.bytes[0]   = ch;
                    grp.byte_count = 3'd1;
                end
            end
            PH_ESC: begin
                n_phase        = PH_BODY;
                grp.byte_count = 3'd1;
                unique case (ch) inside
                    8'h22, 8'h5c, 8'h2f: grp.bytes[0] = ch;
                    8'h62: grp.bytes[0] = 8'h08;
                    8'h66: grp.bytes[0] = 8'h0c;
                    8'h6e: grp.bytes[0] = 8'h0a;
                    8'h72: grp.bytes[0] = 8'h0d;
                    8'h74: grp.bytes[0] = 8'h09;
                    8'h75: begin
                        grp.byte_count = 3'd0;
                        n_phase        = PH_HEX1;
                        n_acc          = '0;
                        n_cnt          = '0;
                    end
                    default: begin
                        grp.byte_count = 3'd0;
                        grp.term       = TERM_ERR;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2: begin
                if (!hexd[4]) begin
                    grp.term = TERM_ERR;
                end else if (r_cnt != 2'd3) begin
                    n_acc = {r_acc[7:0], hexd[3:0]};
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_phase == PH_HEX1) begin
                        if (code >= 16'hd800 && code <= 16'hdbff) begin
                            n_hs    = code[9:0];
                            n_phase = PH_PAIRBS;
                        end else if (code == 16'h0000 ||
                                     (code >= 16'hdc00 && code <= 16'hdfff)) begin
                            // lone low surrogate or zero code
                            grp.term = TERM_ERR;
                        end else begin
                            grp     = utf8_encode({5'd0, code});
                            n_phase = PH_BODY;
                        end
                    end else begin
                        if (code < 16'hdc00 || code > 16'hdfff) begin
                            grp.term = TERM_ERR;
                        end else begin
                            grp     = utf8_encode(pair_cp);
                            n_phase = PH_BODY;
                        end
                    end
                end
            end
            PH_PAIRBS: begin
                if (ch == 8'h5c) n_phase = PH_PAIRU;
                else grp.term = TERM_ERR;
            end
            PH_PAIRU: begin
                if (ch == 8'h75) begin
                    n_phase = PH_HEX2;
                    n_acc   = '0;
                    n_cnt   = '0;
                end else begin
                    grp.term = TERM_ERR;
                end
            end
            default: grp.term = TERM_ERR;
        endcase
        if (grp.term == TERM_ERR) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_cnt   = '0;
        end
        // text ran out inside a string
        if (i_in_data.end_of_text && n_phase != PH_IDLE) begin
            grp.term = TERM_ERR;
            n_phase  = PH_IDLE;
            n_acc    = '0;
            n_cnt    = '0;
        end
    end

    assign o_group = grp;
    assign o_push  = accept && (grp.byte_count != 3'd0 || grp.term != TERM_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_hs    <= n_hs;
        end
    end

endmodule

### design/jsu_queue.sv
// short queue of result groups between front and back
module jsu_queue
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_ctl i_wr,
    output logic    o_full,
    input  t_group  i_group,
    input  logic    i_pop,
    output logic    o_empty,
    output t_group  o_head
);

    t_group         r_mem [QDEPTH];
    logic [QAW:0]   r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[QAW] != r_rd[QAW]) && (r_wr[QAW-1:0] == r_rd[QAW-1:0]);
    assign o_head  = r_mem[r_rd[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr.push) r_mem[r_wr[QAW-1:0]] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_wr.push) r_wr <= r_wr + 1'b1;
            if (i_pop)     r_rd <= r_rd + 1'b1;
        end
    end

endmodule

### design/jsu_back.sv
// back part: walks the head group and sends its results one beat at a time
module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rd_ctl   i_q,
    input  t_group    i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [2:0] r_idx, n_idx;
    logic [2:0] total;
    logic       is_byte;
    logic       is_last;
    logic       fire;

    assign total   = i_head.byte_count + {2'b00, (i_head.term != TERM_NONE)};
    assign is_byte = r_idx < i_head.byte_count;
    assign is_last = (r_idx + 3'd1) == total;

    assign o_out_valid = !i_q.empty;
    assign fire        = o_out_valid && i_out_ready;
    assign o_pop       = fire && is_last;

    always_comb begin
        o_out_data.run_last = is_last;
        if (is_byte) begin
            o_out_data.out_byte = i_head.bytes[r_idx[1:0]];
            o_out_data.status   = ST_BYTE;
        end else begin
            o_out_data.out_byte = 8'h00;
            o_out_data.status   = (i_head.term == TERM_DONE) ? ST_DONE : ST_ERR;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (fire) n_idx = is_last ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= '0;
        else          r_idx <= n_idx;
    end

endmodule

### tb/json_string_unescape_utf8_core_test.sv
// testbench for the json string unescaper: directed, back-pressure and random string streams
`timescale 1ns / 1ps

module json_string_unescape_utf8_core_test;
    import jsu_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_CTRL   = 8'h1f;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_PAIRBS,
        SCAN_PAIRU,
        SCAN_HEX2
    } t_scan;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // decoder shadow state
    t_scan       scan = SCAN_IDLE;
    logic [15:0] hex_acc = '0;
    logic [1:0]  hex_cnt = '0;
    logic [9:0]  hi_bits = '0;

    t_out_item beat_results[$];
    t_out_item pending_results[$];

    int  fail_count = 0;
    int  beats_sent = 0;
    int  idle_cycles = 0;
    int  hold_request = 0;
    int  stall_left = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;

    json_string_unescape_utf8_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int hex_digit(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch - "0");
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        return -1;
    endfunction

    task automatic emit(input logic [7:0] b, input logic [1:0] st);
        t_out_item r;
        r.out_byte = b;
        r.status   = st;
        r.run_last = 1'b0;
        beat_results.push_back(r);
    endtask

    task automatic reject();
        emit(8'h00, ST_ERR);
        scan    = SCAN_IDLE;
        hex_acc = '0;
        hex_cnt = '0;
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            emit(cp[7:0], ST_BYTE);
        end else if (cp <= 21'h7ff) begin
            emit(8'hc0 | {3'b000, cp[10:6]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
        end else if (cp <= 21'hffff) begin
            emit(8'he0 | {4'h0, cp[15:12]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
        end else begin
            emit(8'hf0 | {5'h00, cp[20:18]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[17:12]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
            emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
        end
    endtask

    // works out every result one accepted text beat causes
    task automatic decode_beat(input t_in_item item);
        logic [7:0] ch;
        int         d;
        ch = item.text_byte;
        beat_results.delete();
        case (scan) inside
            SCAN_IDLE: begin
                if (ch == CH_QUOTE) scan = SCAN_BODY;
                else reject();
            end
            SCAN_BODY: begin
                if (ch == CH_QUOTE) begin
                    emit(8'h00, ST_DONE);
                    scan = SCAN_IDLE;
                end else if (ch < 8'h20) begin
                    reject();
                end else if (ch == CH_BSLASH) begin
                    scan = SCAN_ESC;
                end else begin
                    emit(ch, ST_BYTE);
                end
            end
            SCAN_ESC: begin
                scan = SCAN_BODY;
                case (ch) inside
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit(ch, ST_BYTE);
                    "b": emit(8'h08, ST_BYTE);
                    "f": emit(8'h0c, ST_BYTE);
                    "n": emit(8'h0a, ST_BYTE);
                    "r": emit(8'h0d, ST_BYTE);
                    "t": emit(8'h09, ST_BYTE);
                    CH_U: begin
                        scan    = SCAN_HEX1;
                        hex_acc = '0;
                        hex_cnt = '0;
                    end
                    default: reject();
                endcase
            end
            SCAN_HEX1, SCAN_HEX2: begin
                d = hex_digit(ch);
                if (d < 0) begin
                    reject();
                end else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_cnt < 2'd3) begin
                        hex_cnt = hex_cnt + 2'd1;
                    end else begin
                        hex_cnt = '0;
                        if (scan == SCAN_HEX1) begin
                            if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                                hi_bits = hex_acc[9:0];
                                scan    = SCAN_PAIRBS;
                            end else if (hex_acc == 16'h0000 ||
                                         (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff)) begin
                                // zero code or lone low surrogate
                                reject();
                            end else begin
                                emit_utf8({5'b0, hex_acc});
                                scan = SCAN_BODY;
                            end
                        end else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                            reject();
                        end else begin
                            emit_utf8(21'h10000 + {1'b0, hi_bits, hex_acc[9:0]});
                            scan = SCAN_BODY;
                        end
                        hex_acc = '0;
                    end
                end
            end
            SCAN_PAIRBS: begin
                if (ch == CH_BSLASH) scan = SCAN_PAIRU;
                else reject();
            end
            SCAN_PAIRU: begin
                if (ch == CH_U) begin
                    scan    = SCAN_HEX2;
                    hex_acc = '0;
                    hex_cnt = '0;
                end else begin
                    reject();
                end
            end
            default: reject();
        endcase
        // text ran out inside a string
        if (item.end_of_text && scan != SCAN_IDLE) reject();
        if (beat_results.size() > 0) beat_results[$].run_last = 1'b1;
        foreach (beat_results[k]) pending_results.push_back(beat_results[k]);
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic eot);
        t_in_item item;
        int       r;
        item.text_byte   = b;
        item.end_of_text = eot;
        i_in_data  = item;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        decode_beat(item);
        beats_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        r = $urandom_range(0, 99);
        if (tx_gaps_on && r >= 65)
            repeat (r >= 95 ? $urandom_range(8, 25) : $urandom_range(1, 3)) @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], eot_at_end && i == s.len() - 1);
    endtask

    task automatic send_hex(input logic [15:0] v);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int i = 3; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (nib < 4'd10) ch = 8'h30 + {4'h0, nib};
            else ch = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
            send_beat(ch, 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_text("\"hi ~\"", 1'b0);
        send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
        send_text("\"\\u0041\\u00e9\\u07FF\\u20AC\\uFfFf\"", 1'b0);
        send_text("\"\\uD83D\\uDE00\\udbff\\udfff\\uD800\\uDC00\"", 1'b0);
        send_text("x", 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_CTRL, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("\"\\q", 1'b0);
        send_text("\"\\u12g", 1'b0);
        send_text("\"\\u0000", 1'b0);
        send_text("\"\\udc00", 1'b0);
        send_text("\"\\ud800x", 1'b0);
        send_text("\"\\ud800\\n", 1'b0);
        send_text("\"\\ud800\\u0041", 1'b0);
        // raw high bytes go straight through
        send_beat(CH_QUOTE, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h7f, 1'b0);
        send_text(" \"", 1'b0);
        send_text("\"ab", 1'b1);
        send_text("\"\\", 1'b1);
        send_text("\"\\u00", 1'b1);
        send_text("\"\\ud800\\u", 1'b1);
        send_text("\"ok\"", 1'b1);
        send_text("z", 1'b1);
    endtask

    // receiver holds off while four-byte groups pile up behind it
    task automatic test_output_hold();
        hold_request = 120;
        send_beat(CH_QUOTE, 1'b0);
        repeat (8) send_text("\\uDBFF\\uDFFF", 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        send_text("\"\\u20ac", 1'b0);
        wait_drained();
        send_text("x\"", 1'b0);
        wait_drained();
    endtask

    task automatic send_random_string();
        string      esc_letters;
        string      alphabet;
        logic [7:0] b;
        logic [15:0] v;
        esc_letters = "\"\\/bfnrt";
        alphabet    = "\\u0dDcC9fx\"";
        if ($urandom_range(0, 99) < 80) begin
            send_beat(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 3))
                    0: begin
                        do b = 8'($urandom_range(32, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        send_beat(b, 1'b0);
                    end
                    1: begin
                        send_beat(CH_BSLASH, 1'b0);
                        send_beat(esc_letters[$urandom_range(0, 7)], 1'b0);
                    end
                    2: begin
                        case ($urandom_range(0, 2))
                            0: v = 16'($urandom_range(1, 16'h7f));
                            1: v = 16'($urandom_range(16'h80, 16'h7ff));
                            default: begin
                                do v = 16'($urandom_range(16'h800, 16'hffff));
                                while (v >= 16'hd800 && v <= 16'hdfff);
                            end
                        endcase
                        send_text("\\u", 1'b0);
                        send_hex(v);
                    end
                    default: begin
                        send_text("\\u", 1'b0);
                        send_hex(16'($urandom_range(16'hd800, 16'hdbff)));
                        send_text("\\u", 1'b0);
                        send_hex(16'($urandom_range(16'hdc00, 16'hdfff)));
                    end
                endcase
            end
            send_beat(CH_QUOTE, $urandom_range(0, 9) == 0);
        end else if ($urandom_range(0, 1)) begin
            // escape-heavy noise reaches the hex and surrogate phases
            send_text("\"\\u", 1'b0);
            repeat ($urandom_range(1, 8))
                send_beat(alphabet[$urandom_range(0, alphabet.len() - 1)],
                          $urandom_range(0, 15) == 0);
        end else begin
            if ($urandom_range(0, 1)) send_beat(CH_QUOTE, 1'b0);
            repeat ($urandom_range(1, 6))
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic test_random_strings();
        int start_count;
        start_count = beats_sent;
        while (beats_sent - start_count < 40) begin
            tx_gaps_on = $urandom_range(0, 3) != 0;
            send_random_string();
        end
        tx_gaps_on = 1'b1;
    endtask

    // output side: random stalls, quiet stretches and the requested hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_out_ready = 1'b0;
                repeat (hold_request - 1) @(negedge i_clk);
                hold_request = 0;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (rx_stalls_on && $urandom_range(0, 9) == 0)
                    stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                              : $urandom_range(1, 3);
            end
            if ($urandom_range(0, 149) == 0) rx_stalls_on = !rx_stalls_on;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: byte %0h status %0d last %0b",
                       o_out_data.out_byte, o_out_data.status, o_out_data.run_last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte,
                           o_out_data.out_byte);
                    fail_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    fail_count++;
                end
                if (o_out_data.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last,
                           o_out_data.run_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_cases();
        test_output_hold();
        test_pause_until_drained();
        test_random_strings();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
